// File: rtl/hfgb_pkg.sv
// hfgb_pkg: shared widths, constants and types for the float to gamma byte encoder.
// No dependencies; used by hfgb_front, hfgb_sqrt_step, the top level and the test.
`timescale 1ns / 1ps

package hfgb_pkg;

    localparam int SAMPLE_W    = 32;     // binary32 bit pattern
    localparam int LVL_W       = 8;      // encoded level
    localparam int SIG_W       = 24;     // significand with hidden one
    localparam int RAD_W       = 16;     // radicand floor(65025 * v)
    localparam int REM_W       = 10;     // sqrt remainder, at most 2 * root
    localparam int SH_W        = 4;      // residual shift after dropping 24 bits
    localparam int PROD_W      = 40;     // 65025 * significand
    localparam int SQRT_STAGES = 4;      // two root bits per stage

    localparam logic [15:0]      SCALE_K   = 16'd65025;  // 255 squared
    localparam logic [RAD_W-1:0] FULL_RAD  = 16'd65025;  // sqrt gives 255
    localparam logic [7:0]       EXP_ONE   = 8'd127;     // biased exponent of 1.0
    localparam logic [7:0]       EXP_CALC  = 8'd111;     // smallest exponent with a nonzero result
    localparam logic [7:0]       EXP_SHBASE = 8'd126;    // residual shift = 126 - exponent
    localparam logic [7:0]       EXP_ALL1  = 8'hFF;

    typedef enum logic [1:0] {
        MODE_CALC,
        MODE_ZERO,
        MODE_FULL
    } t_mode;

    typedef struct packed {
        logic valid;
        logic nan;
    } t_ctl;

endpackage

// File: rtl/hfgb_front.sv
// hfgb_front: decode, scale and shift stages that turn a binary32 pattern into
// the 16-bit radicand floor(65025 * clamp(v)). Depends on hfgb_pkg.
`timescale 1ns / 1ps

module hfgb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [hfgb_pkg::SAMPLE_W-1:0] i_sample,
    output hfgb_pkg::t_ctl                o_ctl,
    output logic [hfgb_pkg::RAD_W-1:0]    o_rad
);

    // stage 1: classify
    hfgb_pkg::t_ctl                   r1_ctl;
    hfgb_pkg::t_mode                  r1_mode;
    logic [hfgb_pkg::SIG_W-1:0]       r1_sig;
    logic [hfgb_pkg::SH_W-1:0]        r1_sh;
    hfgb_pkg::t_mode                  n1_mode;
    logic                             n1_nan;

    // stage 2: scale
    hfgb_pkg::t_ctl                   r2_ctl;
    hfgb_pkg::t_mode                  r2_mode;
    logic [hfgb_pkg::RAD_W-1:0]       r2_prod_hi;
    logic [hfgb_pkg::SH_W-1:0]        r2_sh;
    logic [hfgb_pkg::PROD_W-1:0]      n2_prod;

    // stage 3: shift
    hfgb_pkg::t_ctl                   r3_ctl;
    logic [hfgb_pkg::RAD_W-1:0]       r3_rad;
    logic [hfgb_pkg::RAD_W-1:0]       n3_rad;

    logic       w_sign;
    logic [7:0] w_expo;
    logic [22:0] w_frac;

    assign w_sign = i_sample[31];
    assign w_expo = i_sample[30:23];
    assign w_frac = i_sample[22:0];

    always_comb begin
        n1_nan  = 1'b0;
        n1_mode = hfgb_pkg::MODE_CALC;
        priority if (w_expo == hfgb_pkg::EXP_ALL1 && w_frac != 23'd0) begin
            n1_nan  = 1'b1;
            n1_mode = hfgb_pkg::MODE_ZERO;
        end else if (w_sign) begin
            n1_mode = hfgb_pkg::MODE_ZERO;
        end else if (w_expo >= hfgb_pkg::EXP_ONE) begin
            n1_mode = hfgb_pkg::MODE_FULL;   // one and above, +inf too
        end else if (w_expo < hfgb_pkg::EXP_CALC) begin
            n1_mode = hfgb_pkg::MODE_ZERO;   // below 2^-16, zero and subnormals
        end else begin
            n1_mode = hfgb_pkg::MODE_CALC;
        end
    end

    // valid bits are reset, data is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
        end else if (i_ce) begin
            r1_ctl.valid <= i_valid;
            r2_ctl.valid <= r1_ctl.valid;
            r3_ctl.valid <= r2_ctl.valid;
        end
        if (i_ce) begin
            r1_ctl.nan <= n1_nan;
            r1_mode    <= n1_mode;
            r1_sig     <= {1'b1, w_frac};
            r1_sh      <= hfgb_pkg::SH_W'(hfgb_pkg::EXP_SHBASE - w_expo);

            r2_ctl.nan <= r1_ctl.nan;
            r2_mode    <= r1_mode;
            r2_prod_hi <= n2_prod[hfgb_pkg::PROD_W-1 -: hfgb_pkg::RAD_W];
            r2_sh      <= r1_sh;

            r3_ctl.nan <= r2_ctl.nan;
            r3_rad     <= n3_rad;
        end
    end

    // product < 2^40 and total shift >= 24, so only the top 16 bits matter
    assign n2_prod = {16'd0, r1_sig} * {24'd0, hfgb_pkg::SCALE_K};

    always_comb begin
        unique case (r2_mode)
            hfgb_pkg::MODE_CALC: n3_rad = r2_prod_hi >> r2_sh;
            hfgb_pkg::MODE_FULL: n3_rad = hfgb_pkg::FULL_RAD;
            default:             n3_rad = '0;
        endcase
    end

    assign o_ctl = r3_ctl;
    assign o_rad = r3_rad;

endmodule

// File: rtl/hfgb_sqrt_step.sv
// hfgb_sqrt_step: one pipeline stage of the digit-by-digit integer square root,
// producing two root bits per stage. Depends on hfgb_pkg.
`timescale 1ns / 1ps

module hfgb_sqrt_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  hfgb_pkg::t_ctl                i_ctl,
    input  logic [hfgb_pkg::RAD_W-1:0]    i_rad,
    input  logic [hfgb_pkg::REM_W-1:0]    i_rem,
    input  logic [hfgb_pkg::LVL_W-1:0]    i_root,
    output hfgb_pkg::t_ctl                o_ctl,
    output logic [hfgb_pkg::RAD_W-1:0]    o_rad,
    output logic [hfgb_pkg::REM_W-1:0]    o_rem,
    output logic [hfgb_pkg::LVL_W-1:0]    o_root
);

    localparam int TMP_W = hfgb_pkg::REM_W + 2;

    hfgb_pkg::t_ctl                   r_ctl;
    logic [hfgb_pkg::RAD_W-1:0]       r_rad;
    logic [hfgb_pkg::REM_W-1:0]       r_rem;
    logic [hfgb_pkg::LVL_W-1:0]       r_root;
    logic [hfgb_pkg::RAD_W-1:0]       n_rad;
    logic [hfgb_pkg::REM_W-1:0]       n_rem;
    logic [hfgb_pkg::LVL_W-1:0]       n_root;

    // two dependent restoring steps; radicand is consumed from the top
    always_comb begin
        logic [TMP_W-1:0] tmp;
        logic [TMP_W-1:0] trial;
        n_rad  = i_rad;
        n_rem  = i_rem;
        n_root = i_root;
        for (int k = 0; k < 2; k++) begin
            tmp   = {n_rem, n_rad[hfgb_pkg::RAD_W-1 -: 2]};
            trial = TMP_W'({n_root, 2'b01});
            n_rad = {n_rad[hfgb_pkg::RAD_W-3:0], 2'b00};
            if (tmp >= trial) begin
                n_rem  = hfgb_pkg::REM_W'(tmp - trial);
                n_root = {n_root[hfgb_pkg::LVL_W-2:0], 1'b1};
            end else begin
                n_rem  = hfgb_pkg::REM_W'(tmp);
                n_root = {n_root[hfgb_pkg::LVL_W-2:0], 1'b0};
            end
        end
    end

    // valid bit is reset, data is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_ce) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_ce) begin
            r_ctl.nan <= i_ctl.nan;
            r_rad     <= n_rad;
            r_rem     <= n_rem;
            r_root    <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// File: rtl/hdr_float_to_gamma_byte.sv
// hdr_float_to_gamma_byte: top level of the square-root gamma byte encoder.
// Depends on hfgb_pkg, hfgb_front and hfgb_sqrt_step.
`timescale 1ns / 1ps

// One binary32 sample word in, one 8-bit level word out: level is
// floor(255 * sqrt(clamp(v, 0, 1))). Negatives, zero and subnormals give 0,
// values of one and above (and +inf) give 255, and a NaN gives 0 with tuser
// set. The block takes one word per clock unless a valid output word waits
// untaken, and has three front stages (classify, constant multiply by 65025,
// shift to the 16-bit radicand) followed by four square-root stages of two
// root bits each. The whole pipeline advances together; when the output word
// is not taken, every stage holds, and s_tready drops only while a valid
// output word waits, so nothing is lost or repeated under backpressure. No
// configuration, no state beyond the pipeline.
module hdr_float_to_gamma_byte (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] sample_bits
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] level
    output logic        o_m_tuser    // [0] was_nan
);

    localparam int NS = hfgb_pkg::SQRT_STAGES;

    logic w_ce;

    hfgb_pkg::t_ctl                   w_ctl  [NS+1];
    logic [hfgb_pkg::RAD_W-1:0]       w_rad  [NS+1];
    logic [hfgb_pkg::REM_W-1:0]       w_rem  [NS+1];
    logic [hfgb_pkg::LVL_W-1:0]       w_root [NS+1];

    // pipeline moves when the output slot is free or being drained
    assign w_ce       = !w_ctl[NS].valid || i_m_tready;
    assign o_s_tready = w_ce;

    hfgb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (w_ce),
        .i_valid  (i_s_tvalid),
        .i_sample (i_s_tdata),
        .o_ctl    (w_ctl[0]),
        .o_rad    (w_rad[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        hfgb_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_ctl   (w_ctl[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    // last sqrt stage registers are the output register
    assign o_m_tvalid = w_ctl[NS].valid;
    assign o_m_tdata  = w_root[NS];
    assign o_m_tuser  = w_ctl[NS].nan;

endmodule

// File: rtl/hfgb_checker.sv
// hfgb_checker: port-level assertions for hdr_float_to_gamma_byte, bound to it.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module hfgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tuser
);

    // output word stays offered while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped under stall");

    // a NaN result always carries level zero
    a_nan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 8'd0)
        else $error("nan flag with nonzero level");

    // input stalls only while a valid output word is blocked
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output slot");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("valid output after reset");

endmodule

bind hdr_float_to_gamma_byte hfgb_checker u_hfgb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: tb/sv/hdr_float_to_gamma_byte_test.sv
// hdr_float_to_gamma_byte_test: self-checking stream test of the square-root gamma byte encoder.
// Depends on hfgb_pkg and hdr_float_to_gamma_byte; predicts each level word in place.
`timescale 1ns / 1ps

module hdr_float_to_gamma_byte_test;

    // one predicted output word
    typedef struct {
        logic [hfgb_pkg::LVL_W-1:0]    level;
        logic                          nan;
        logic [hfgb_pkg::SAMPLE_W-1:0] sample;   // kept for the mismatch line
    } t_level_word;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [hfgb_pkg::SAMPLE_W-1:0] s_tdata;      // [31:0] sample_bits
    logic                          m_tvalid;
    logic                          m_tready;
    logic [hfgb_pkg::LVL_W-1:0]    m_tdata;      // [7:0] level
    logic                          m_tuser;      // [0] was_nan

    t_level_word expected_levels[$];   // words in flight, oldest first
    int          mismatch_count;
    int          tx_gap_max;           // sender idle cycles per word: 0..tx_gap_max
    int          rx_stall_max;         // receiver stall cycles per word: 0..rx_stall_max
    int          rx_long_hold;         // one-shot long receiver hold-off, in cycles

    hdr_float_to_gamma_byte uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // floor(sqrt(n)) for n below 2^16, one root bit at a time
    function automatic logic [hfgb_pkg::LVL_W-1:0] root_floor(input logic [63:0] n);
        logic [hfgb_pkg::LVL_W-1:0] r;
        logic [hfgb_pkg::LVL_W-1:0] t;
        r = '0;
        for (int b = hfgb_pkg::LVL_W - 1; b >= 0; b--) begin
            t = r | (hfgb_pkg::LVL_W'(1) << b);
            if ({48'd0, 8'd0, t} * {48'd0, 8'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    // level = floor(sqrt(floor(65025 * v))), v clamped to [0, 1]
    function automatic t_level_word gamma_encode(input logic [hfgb_pkg::SAMPLE_W-1:0] bits);
        t_level_word w;
        logic        sgn;
        logic [7:0]  expo;
        logic [22:0] frac;
        logic [63:0] prod;
        int unsigned sh;
        sgn  = bits[31];
        expo = bits[30:23];
        frac = bits[22:0];
        w.sample = bits;
        w.nan    = 1'b0;
        w.level  = '0;
        if (expo == hfgb_pkg::EXP_ALL1 && frac != '0) begin
            w.nan = 1'b1;                       // NaN: forced to zero, flagged
        end else if (sgn) begin
            w.level = '0;                       // negatives incl. -0 and -inf
        end else if (expo >= hfgb_pkg::EXP_ONE) begin
            w.level = 8'hFF;                    // one and above, +inf
        end else if (expo != 8'd0) begin        // zero and subnormals stay 0
            prod = 64'(hfgb_pkg::SCALE_K) * {40'd0, 1'b1, frac};
            sh   = 150 - int'(expo);
            if (sh < 64) w.level = root_floor(prod >> sh);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [hfgb_pkg::SAMPLE_W-1:0] sample,
                                   input int got, input int want);
        $display("MISMATCH %s sample=%08h got=%0d want=%0d", what, sample, got, want);
        mismatch_count++;
    endtask

    // send one sample word; returns at the edge where it is taken
    task automatic send_sample(input logic [hfgb_pkg::SAMPLE_W-1:0] bits);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        do @(posedge i_clk); while (!s_tready);
        expected_levels.insert(expected_levels.size(), gamma_encode(bits));
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    // hold the sender until every word in flight has come out
    task automatic wait_drained();
        sender_idle();
        while (expected_levels.size() != 0) @(posedge i_clk);
    endtask

    // mostly in-range values, with specials and raw patterns mixed in
    function automatic logic [hfgb_pkg::SAMPLE_W-1:0] random_sample();
        logic [22:0] frac;
        frac = 23'($urandom());
        unique case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: return {1'b0, 8'($urandom_range(126, 100)), frac};
            6:       return $urandom();
            7:       return {1'($urandom()),
                             ($urandom_range(1, 0) ? hfgb_pkg::EXP_ALL1 : 8'd0),
                             ($urandom_range(3, 0) == 0) ? 23'd0 : frac};
            8:       return {1'b0, 8'($urandom_range(254, 127)), frac};
            default: return {1'b1, 8'($urandom_range(254, 1)), frac};
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_sample(random_sample());
    endtask

    // edges of every class and the rounding boundaries
    task automatic test_directed();
        logic [hfgb_pkg::SAMPLE_W-1:0] v[24];
        v = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000,
              32'h3F7F_FFFF, 32'h3F00_0000, 32'h3E80_0000, 32'h0080_0000,
              32'h0000_0001, 32'h007F_FFFF, 32'h8000_0001, 32'h3780_0000,
              32'h3781_0000, 32'h37FF_FFFF, 32'h3700_0000, 32'h7F7F_FFFF,
              32'hBF80_0000, 32'h3C80_0000, 32'h4000_0000, 32'h3F7F_0000};
        tx_gap_max   = 3;
        rx_stall_max = 3;
        foreach (v[i]) send_sample(v[i]);
        wait_drained();
    endtask

    task automatic test_random_idling(input int count);
        tx_gap_max   = 15;
        rx_stall_max = 15;
        send_random(count);
    endtask

    // back to back on both sides, one word per clock
    task automatic test_full_rate(input int count);
        tx_gap_max   = 0;
        rx_stall_max = 0;
        send_random(count);
    endtask

    // receiver stops for a long stretch so the pipeline fills and s_tready drops
    task automatic test_backpressure(input int count);
        tx_gap_max   = 0;
        rx_stall_max = 2;
        rx_long_hold = 200;
        send_random(count);
    endtask

    // bursts separated by full drains
    task automatic test_drain_bursts(input int bursts, input int count);
        tx_gap_max   = 4;
        rx_stall_max = 6;
        for (int b = 0; b < bursts; b++) begin
            send_random(count);
            wait_drained();
        end
    endtask

    // receiver: per word draw a stall, then take the word
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_long_hold > 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (rx_long_hold - 1) @(negedge i_clk);
                rx_long_hold = 0;
            end
            stall = (rx_stall_max > 0) ? $urandom_range(rx_stall_max, 0) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge i_clk) begin
        t_level_word w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected word", '0, int'(m_tdata), -1);
            end else begin
                w = expected_levels.pop_front();
                if (m_tdata !== w.level)
                    report_mismatch("level", w.sample, int'(m_tdata), int'(w.level));
                if (m_tuser !== w.nan)
                    report_mismatch("was_nan", w.sample, int'(m_tuser), int'(w.nan));
            end
        end
    end

    // run-time limit
    initial begin
        #5_000_000;
        $display("hdr_float_to_gamma_byte_test failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        tx_gap_max     = 0;
        rx_stall_max   = 0;
        rx_long_hold   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_idling(600);
        test_full_rate(200);
        test_backpressure(80);
        test_drain_bursts(3, 50);
        test_random_idling(450);
        test_full_rate(120);

        sender_idle();
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);   // catch any extra word after the drain
        if (mismatch_count == 0) begin
            $display("hdr_float_to_gamma_byte_test passed");
        end else begin
            $display("hdr_float_to_gamma_byte_test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/hfgb_pkg.sv
rtl/hfgb_front.sv
rtl/hfgb_sqrt_step.sv
rtl/hdr_float_to_gamma_byte.sv
rtl/hfgb_checker.sv
tb/sv/hdr_float_to_gamma_byte_test.sv
